### hw/rtl/npc_pkg.sv
package npc_pkg;

  localparam int SLOTS = 6;

  localparam logic [7:0] SYM_A    = 8'h41;
  localparam logic [7:0] SYM_C    = 8'h43;
  localparam logic [7:0] SYM_G    = 8'h47;
  localparam logic [7:0] SYM_T    = 8'h54;
  localparam logic [7:0] SYM_N    = 8'h4E;
  localparam logic [7:0] SYM_GAP  = 8'h2D;
  localparam logic [7:0] SYM_PLUS = 8'h2B;

  localparam logic [12:0] CONS_LEN_MAX = 13'd8191;
  localparam logic [12:0] ALEN_RESET   = 13'd4096;

  typedef enum logic [1:0] {
    OP_ACC     = 2'd0,
    OP_CALL    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_LEFT  = 2'd0,
    CFG_RIGHT = 2'd1,
    CFG_ALEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SLOT_A    = 3'd0,
    SLOT_C    = 3'd1,
    SLOT_G    = 3'd2,
    SLOT_T    = 3'd3,
    SLOT_N    = 3'd4,
    SLOT_GAP  = 3'd5,
    SLOT_NONE = 3'd6
  } slot_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ACC,
    KIND_CALL,
    KIND_RESTART
  } kind_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic restart;
    logic rd;
    logic acc;
    logic wr;
    logic cmp1;
    logic cmp2;
    logic emit;
  } npc_cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_t in_kind;
    kind_t kind;
    logic  out_busy;
  } npc_stat_t;

  function automatic slot_t slot_of(input logic [7:0] ch);
    logic [7:0] up;
    slot_t      s;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    case (up)
      8'h41: s = SLOT_A;
      8'h43: s = SLOT_C;
      8'h47: s = SLOT_G;
      8'h54, 8'h55: s = SLOT_T;
      8'h52, 8'h59, 8'h53, 8'h57, 8'h4B, 8'h4D,
      8'h42, 8'h44, 8'h48, 8'h56, 8'h4E: s = SLOT_N;
      8'h2D: s = SLOT_GAP;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/npc_in_if.sv
interface npc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] column;
  logic [7:0]  residue;
  logic [31:0] abundance;

  modport source(output valid, output opcode, output column, output residue,
                 output abundance, input ready);
  modport sink(input valid, input opcode, input column, input residue,
               input abundance, output ready);
endinterface

### hw/rtl/npc_out_if.sv
interface npc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  column_symbol;
  logic        in_consensus;
  logic [12:0] consensus_position;

  modport source(output valid, output column_symbol, output in_consensus,
                 output consensus_position, input ready);
  modport sink(input valid, input column_symbol, input in_consensus,
               input consensus_position, output ready);
endinterface

### hw/rtl/npc_cfg_if.sv
interface npc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/npc_ctrl.sv
module npc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  npc_pkg::npc_stat_t stat,
  output npc_pkg::npc_cmd_t  cmd,
  output logic               in_ready
);
  import npc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ACC,
    S_WRITE,
    S_CMP1,
    S_CMP2,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.restart = (stat.in_kind == KIND_RESTART);
          if (stat.in_kind == KIND_ACC || stat.in_kind == KIND_CALL) state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = (stat.kind == KIND_ACC) ? S_ACC : S_CMP1;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CMP1: begin
        cmd.cmp1  = 1'b1;
        state_nxt = S_CMP2;
      end
      S_CMP2: begin
        cmd.cmp2  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/npc_datapath.sv
module npc_datapath #(
  parameter int MAX_COLUMNS  = 4096,
  parameter int COUNTER_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  npc_pkg::npc_cmd_t  cmd,
  output npc_pkg::npc_stat_t stat,
  input  logic [1:0]         in_opcode,
  input  logic [11:0]        in_column,
  input  logic [7:0]         in_residue,
  input  logic [31:0]        in_abundance,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_column_symbol,
  output logic               out_in_consensus,
  output logic [12:0]        out_consensus_position
);
  import npc_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CB = COUNTER_BITS;

  typedef logic [SLOTS-1:0][CB-1:0] row_t;

  row_t mem [MAX_COLUMNS];
  row_t rdata_r;
  row_t wdata;

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] addr;
  logic          mem_we;

  // latched request
  logic [11:0] col_r;
  slot_t       slot_r;
  logic [31:0] abund_r;
  kind_t       kind_r;
  kind_t       in_kind;
  logic        stored;
  logic [31:0] col_ext;

  // config
  logic [11:0] left_r;
  logic [11:0] right_r;
  logic [12:0] alen_r;
  logic [12:0] cons_len_r;

  // compare pipeline
  logic [CB-1:0] sum_r;
  logic [CB:0]   sum_wide;
  logic [CB-1:0] m1_r, m2_r, n_r, gap_r, best_r;
  logic [7:0]    s1_r, s2_r, bsym_r;
  logic          censor_r;
  row_t          cnt;

  logic          out_valid_r;
  logic [7:0]    sym_r;
  logic          incons_r;
  logic [12:0]   pos_r;

  always_comb begin
    case (op_t'(in_opcode))
      OP_ACC:     in_kind = (slot_of(in_residue) != SLOT_NONE) &&
                            (32'(in_column) < 32'(MAX_COLUMNS)) ? KIND_ACC : KIND_NONE;
      OP_CALL:    in_kind = KIND_CALL;
      OP_RESTART: in_kind = KIND_RESTART;
      default:    in_kind = KIND_NONE;
    endcase
  end

  assign col_ext = 32'(col_r);
  assign stored  = (col_ext < 32'(MAX_COLUMNS));
  assign addr    = cmd.clr_step ? clr_cnt_r : col_ext[AW-1:0];

  assign sum_wide = {1'b0, rdata_r[slot_r]} + (CB+1)'(abund_r);

  always_comb begin
    wdata  = '0;
    mem_we = 1'b0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.wr) begin
      wdata         = rdata_r;
      wdata[slot_r] = sum_r;
      mem_we        = 1'b1;
    end else if (cmd.cmp1 && stored) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata;
    if (cmd.rd) rdata_r <= mem[addr];
  end

  // counters of a column beyond the store read as zero
  assign cnt = stored ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_column;
      slot_r  <= slot_of(in_residue);
      abund_r <= in_abundance;
    end
    if (cmd.acc) sum_r <= sum_wide[CB] ? {CB{1'b1}} : sum_wide[CB-1:0];
    if (cmd.cmp1) begin
      // tie keeps the earlier base
      if (cnt[SLOT_C] > cnt[SLOT_A]) begin
        m1_r <= cnt[SLOT_C];
        s1_r <= SYM_C;
      end else begin
        m1_r <= cnt[SLOT_A];
        s1_r <= SYM_A;
      end
      if (cnt[SLOT_T] > cnt[SLOT_G]) begin
        m2_r <= cnt[SLOT_T];
        s2_r <= SYM_T;
      end else begin
        m2_r <= cnt[SLOT_G];
        s2_r <= SYM_G;
      end
      n_r      <= cnt[SLOT_N];
      gap_r    <= cnt[SLOT_GAP];
      censor_r <= ({1'b0, col_r} >= alen_r) || (col_r < left_r) ||
                  (({2'b00, col_r} + {2'b00, right_r}) >= {1'b0, alen_r});
    end
    if (cmd.cmp2) begin
      if (m2_r > m1_r) begin
        best_r <= m2_r;
        bsym_r <= s2_r;
      end else if (m1_r == '0) begin
        // no base seen: ambiguity count stands in, symbol N either way
        best_r <= n_r;
        bsym_r <= SYM_N;
      end else begin
        best_r <= m1_r;
        bsym_r <= s1_r;
      end
    end
    if (cmd.emit) begin
      if (censor_r) begin
        sym_r    <= SYM_PLUS;
        incons_r <= 1'b0;
        pos_r    <= '0;
      end else if (best_r >= gap_r) begin
        sym_r    <= bsym_r;
        incons_r <= 1'b1;
        pos_r    <= cons_len_r;
      end else begin
        sym_r    <= SYM_GAP;
        incons_r <= 1'b0;
        pos_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      kind_r      <= KIND_NONE;
      left_r      <= '0;
      right_r     <= '0;
      alen_r      <= ALEN_RESET;
      cons_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.load) kind_r <= in_kind;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEFT:  left_r  <= cfg_data[11:0];
          CFG_RIGHT: right_r <= cfg_data[11:0];
          CFG_ALEN:  alen_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.restart) begin
        cons_len_r <= '0;
      end else if (cmd.emit && !censor_r && best_r >= gap_r &&
                   cons_len_r != CONS_LEN_MAX) begin
        cons_len_r <= cons_len_r + 13'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last = (clr_cnt_r == AW'(MAX_COLUMNS - 1));
  assign stat.in_kind  = in_kind;
  assign stat.kind     = kind_r;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid              = out_valid_r;
  assign out_column_symbol      = sym_r;
  assign out_in_consensus       = incons_r;
  assign out_consensus_position = pos_r;

endmodule

### hw/rtl/nucleotide_profile_consensus.sv
// Majority-vote consensus over a profile of alignment columns.
// in_ch: one request per column update (opcode 0: add abundance to the
//   residue's saturating counter), column call (opcode 1) or consensus
//   restart (opcode 2). in_ch.ready is high only while the block is idle.
// out_ch: one result per call: symbol, in-consensus flag, consensus index.
// cfg_ch: register writes (0 left censor, 1 right censor, 2 alignment
//   length); always ready, write only while no request is in flight.
// Sequence: restart and ignored requests complete at acceptance; an
//   accumulate steps through accept, read, add, write back; a call steps
//   through accept, read, two compare steps, result, and the result is
//   registered into the output after the last step. The single-port counter
//   memory and its read-modify-write loop set this sequence.
// Reset: a clearing pass zeroes all MAX_COLUMNS columns of the counter
//   memory, one column per cycle; no request is accepted until it ends.
// Stall: a result waits in the output register; the next call holds in its
//   last step until that result is taken, other requests go on.
module nucleotide_profile_consensus #(
  parameter int MAX_COLUMNS  = 4096,
  parameter int COUNTER_BITS = 48
) (
  input logic clk,
  input logic rst_n,
  npc_in_if.sink    in_ch,
  npc_out_if.source out_ch,
  npc_cfg_if.sink   cfg_ch
);
  import npc_pkg::*;

  npc_cmd_t  cmd;
  npc_stat_t stat;
  logic      cfg_we;

  // config registers take a write every cycle
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  npc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  npc_datapath #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_opcode              (in_ch.opcode),
    .in_column              (in_ch.column),
    .in_residue             (in_ch.residue),
    .in_abundance           (in_ch.abundance),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_ch.index),
    .cfg_data               (cfg_ch.data),
    .out_ready              (out_ch.ready),
    .out_valid              (out_ch.valid),
    .out_column_symbol      (out_ch.column_symbol),
    .out_in_consensus       (out_ch.in_consensus),
    .out_consensus_position (out_ch.consensus_position)
  );

endmodule
